// ===== hw/rtl/slcan_pkg.sv =====
package slcan_pkg;

  // identifier split defaults
  localparam int DEF_PRIORITY_BITS = 1;
  localparam int DEF_TYPE_BITS     = 8;
  localparam int DEF_RESERVED_BITS = 2;
  localparam int DEF_DEST_BITS     = 9;
  localparam int DEF_SOURCE_BITS   = 9;
  localparam int DEF_MAX_LINE      = 27;

  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_BELL = 8'd7;
  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_8    = 8'h38;

  localparam logic [4:0] COUNT_MAX = 5'd31;

  localparam int PRIO_W  = 1;
  localparam int TYPE_W  = 8;
  localparam int DEST_W  = 9;
  localparam int SRC_W   = 9;
  localparam int LEN_W   = 4;
  localparam int DATA_W  = 64;
  localparam int FIELDS_W = PRIO_W + TYPE_W + DEST_W + SRC_W + LEN_W + DATA_W;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_REJECT = 2'd2
  } line_kind_t;

  typedef struct packed {
    line_kind_t          kind;
    logic [PRIO_W-1:0]   priority_res;
    logic [TYPE_W-1:0]   msg_type;
    logic [DEST_W-1:0]   destination;
    logic [SRC_W-1:0]    source;
    logic [LEN_W-1:0]    data_len;
    logic [DATA_W-1:0]   data_bytes;
  } result_t;

  // bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    return v;
  endfunction

endpackage

// ===== hw/rtl/slcan_line_receiver_top.sv =====
// slcan line receiver: one ascii character per transaction on s_axis
// throughput: one character per cycle while the skid register is empty, a terminator gives one result transaction
// latency: a result is on m_axis the cycle after its terminator when the result register is free
// a skid register behind the result register holds one more result; input stalls only while both are full
// reset: synchronous, clears the line state and both output entries
module slcan_line_receiver_top #(
  parameter int PRIORITY_BITS = slcan_pkg::DEF_PRIORITY_BITS,
  parameter int TYPE_BITS     = slcan_pkg::DEF_TYPE_BITS,
  parameter int RESERVED_BITS = slcan_pkg::DEF_RESERVED_BITS,
  parameter int DEST_BITS     = slcan_pkg::DEF_DEST_BITS,
  parameter int SOURCE_BITS   = slcan_pkg::DEF_SOURCE_BITS,
  parameter int MAX_LINE      = slcan_pkg::DEF_MAX_LINE
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // rx_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // priority_res, msg_type, destination, source, data_len, data_bytes, zero pad
  output logic [slcan_pkg::TDATA_W-1:0]    m_axis_tdata,
  output logic [1:0]                       m_axis_tuser    // line_kind
);
  import slcan_pkg::*;

  localparam int ShDest = SOURCE_BITS;
  localparam int ShType = SOURCE_BITS + DEST_BITS + RESERVED_BITS;
  localparam int ShPrio = ShType + TYPE_BITS;
  localparam logic [63:0] PrioMask = (64'd1 << PRIORITY_BITS) - 64'd1;
  localparam logic [63:0] TypeMask = (64'd1 << TYPE_BITS) - 64'd1;
  localparam logic [63:0] DestMask = (64'd1 << DEST_BITS) - 64'd1;
  localparam logic [63:0] SrcMask  = (64'd1 << SOURCE_BITS) - 64'd1;

  // line state
  logic [4:0]  char_count;
  logic [7:0]  command_char;
  logic [31:0] id_accum;
  logic [3:0]  length_digit;
  logic [63:0] payload_shift;
  logic        bad_line;

  logic [4:0]  char_count_next;
  logic [7:0]  command_char_next;
  logic [31:0] id_accum_next;
  logic [3:0]  length_digit_next;
  logic [63:0] payload_shift_next;
  logic        bad_line_next;

  // output entries
  logic    out_valid;
  logic    skid_valid;
  result_t out_res;
  result_t skid_res;
  result_t new_res;

  logic       in_take;
  logic       out_take;
  logic       is_term;
  logic       term_take;
  logic [7:0] c;
  logic [4:0] hv;
  logic [4:0] pos_off;
  logic [3:0] pair_idx;
  logic [3:0] nib_idx;
  logic [5:0] expect_count;
  logic       frame_ok;
  logic [63:0] id_wide;

  assign c         = s_axis_tdata;
  assign hv        = hex_value(c);
  assign is_term   = (c == CHAR_CR) || (c == CHAR_BELL);
  assign s_axis_tready = !skid_valid;
  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign term_take = in_take && is_term;
  assign out_take  = out_valid && m_axis_tready;

  assign pos_off  = char_count - 5'd10;
  assign pair_idx = pos_off[4:1];
  // even offset is the high nibble of the byte
  assign nib_idx  = {pair_idx[2:0], ~pos_off[0]};

  always_comb begin
    char_count_next    = char_count;
    command_char_next  = command_char;
    id_accum_next      = id_accum;
    length_digit_next  = length_digit;
    payload_shift_next = payload_shift;
    bad_line_next      = bad_line;
    if (is_term) begin
      char_count_next    = '0;
      command_char_next  = '0;
      id_accum_next      = '0;
      length_digit_next  = '0;
      payload_shift_next = '0;
      bad_line_next      = 1'b0;
    end else begin
      if (char_count == 5'd0) begin
        command_char_next = c;
      end else if (char_count <= 5'd8) begin
        if (hv[4]) bad_line_next = 1'b1;
        else id_accum_next = {id_accum[27:0], hv[3:0]};
      end else if (char_count == 5'd9) begin
        if (c >= CHAR_0 && c <= CHAR_8) length_digit_next = 4'(c - CHAR_0);
        else bad_line_next = 1'b1;
      end else begin
        if (hv[4] || pair_idx >= 4'd8) bad_line_next = 1'b1;
        else payload_shift_next = payload_shift | (64'(hv[3:0]) << {nib_idx, 2'b00});
      end
      if (char_count < COUNT_MAX) char_count_next = char_count + 5'd1;
    end
  end

  assign id_wide      = {32'd0, id_accum};
  assign expect_count = 6'd10 + {1'b0, length_digit, 1'b0};
  assign frame_ok = !bad_line && (command_char == CHAR_T) &&
                    ({1'b0, char_count} == expect_count) &&
                    ({1'b0, char_count} < 6'(MAX_LINE));

  always_comb begin
    new_res = '0;
    if (char_count == 5'd0) begin
      new_res.kind = KIND_ACK;
    end else if (frame_ok) begin
      new_res.kind         = KIND_FRAME;
      new_res.priority_res = PRIO_W'((id_wide >> ShPrio) & PrioMask);
      new_res.msg_type     = TYPE_W'((id_wide >> ShType) & TypeMask);
      new_res.destination  = DEST_W'((id_wide >> ShDest) & DestMask);
      new_res.source       = SRC_W'(id_wide & SrcMask);
      new_res.data_len     = length_digit;
      new_res.data_bytes   = payload_shift;
    end else begin
      new_res.kind = KIND_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count    <= '0;
      command_char  <= '0;
      id_accum      <= '0;
      length_digit  <= '0;
      payload_shift <= '0;
      bad_line      <= 1'b0;
    end else if (in_take) begin
      char_count    <= char_count_next;
      command_char  <= command_char_next;
      id_accum      <= id_accum_next;
      length_digit  <= length_digit_next;
      payload_shift <= payload_shift_next;
      bad_line      <= bad_line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) skid_valid <= 1'b0;
    end else if (term_take) begin
      if (out_valid && !out_take) skid_valid <= 1'b1;
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) out_res <= skid_res;
    end else if (term_take) begin
      if (!out_valid || out_take) out_res <= new_res;
      else skid_res <= new_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tdata  = TDATA_W'({out_res.data_bytes, out_res.data_len, out_res.source,
                                   out_res.destination, out_res.msg_type,
                                   out_res.priority_res});

endmodule

// ===== hw/rtl/slcan_checker.sv =====
module slcan_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [7:0]                    s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [slcan_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                    m_axis_tuser
);
  import slcan_pkg::*;

  localparam int LenLo = PRIO_W + TYPE_W + DEST_W + SRC_W;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // an accepted terminator always leaves a result waiting
  a_term_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready &&
     (s_axis_tdata == CHAR_CR || s_axis_tdata == CHAR_BELL)) |=> m_axis_tvalid)
    else $error("terminator gave no result");

  a_nonframe_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != KIND_FRAME) |-> (m_axis_tdata == '0))
    else $error("ack or reject carries nonzero fields");

  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_FRAME) |->
      (m_axis_tdata[LenLo+LEN_W-1:LenLo] <= 4'd8))
    else $error("frame length above eight");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind slcan_line_receiver_top slcan_checker u_slcan_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
